>>> sv/ptc_pkg.sv
// Shared types for the pressure/temperature compensation core.
// No dependencies; imported by ptc_muldiv and the top level.
package ptc_pkg;

  typedef struct packed {
    logic        action;
    logic [19:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] temperature_centi;
    logic [24:0]        pressure_q24_8;
    logic               divide_fault;
  } out_item_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } unit_op_e;

  // request to the shared multiply/divide unit
  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_STEP = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

endpackage

>>> sv/ptc_muldiv.sv
// Shared 64-bit shift/add unit: serial multiply (mod 2^64) and signed
// restoring divide (truncating). Depends on ptc_pkg.
module ptc_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptc_pkg::unit_req_t req_i,
  input  logic [63:0]       a_i,
  input  logic [63:0]       b_i,
  output logic              done_o,
  output logic [63:0]       result_o
);
  import ptc_pkg::*;

  logic        busy_q, busy_d;
  unit_op_e    op_q, op_d;
  logic [63:0] a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;

  logic [64:0] add_x, add_y, sum;
  logic        cin;
  logic [63:0] sh;
  logic [63:0] mag_a, mag_b;

  assign sh    = {acc_q[62:0], a_q[63]};
  assign mag_a = a_i[63] ? (64'd0 - a_i) : a_i;
  assign mag_b = b_i[63] ? (64'd0 - b_i) : b_i;

  // the one adder
  always_comb begin
    if (op_q == OP_MUL) begin
      add_x = {1'b0, acc_q};
      add_y = {1'b0, a_q};
      cin   = 1'b0;
    end else begin
      add_x = {1'b0, sh};
      add_y = {1'b0, ~b_q};
      cin   = 1'b1;
    end
    sum = add_x + add_y + {64'd0, cin};
  end

  always_comb begin
    busy_d   = busy_q;
    op_d     = op_q;
    a_d      = a_q;
    b_d      = b_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    neg_d    = neg_q;
    done_o   = 1'b0;
    result_o = acc_q;
    if (!busy_q) begin
      if (req_i.start) begin
        busy_d = 1'b1;
        op_d   = req_i.op;
        acc_d  = 64'd0;
        cnt_d  = 7'd0;
        if (req_i.op == OP_MUL) begin
          a_d = a_i;
          b_d = b_i;
        end else begin
          a_d   = mag_a;
          b_d   = mag_b;
          neg_d = a_i[63] ^ b_i[63];
        end
      end
    end else if (op_q == OP_MUL) begin
      if (b_q == 64'd0) begin
        done_o = 1'b1;
        busy_d = 1'b0;
      end else begin
        if (b_q[0]) acc_d = sum[63:0];
        a_d = {a_q[62:0], 1'b0};
        b_d = {1'b0, b_q[63:1]};
      end
    end else begin
      if (cnt_q[6]) begin
        done_o   = 1'b1;
        busy_d   = 1'b0;
        result_o = neg_q ? (64'd0 - a_q) : a_q;
      end else begin
        // sum[64] set means no borrow: divisor fits
        if (sum[64]) acc_d = sum[63:0];
        else         acc_d = sh;
        a_d   = {a_q[62:0], sum[64]};
        cnt_d = cnt_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= OP_MUL;
    end else begin
      busy_q <= busy_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
  end

endmodule

>>> sv/pressure_temperature_compensation_core.sv
// Top level of the pressure/temperature compensation core.
// Depends on ptc_pkg and ptc_muldiv.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i): one request holds
//    an action bit (0 temperature, 1 pressure) and a 20-bit raw reading.
//  - Output channel (out_valid_o / out_stall_i / out_data_o): one result per
//    request. A temperature request updates the kept fine temperature.
//  - Config channel (cfg_valid_i / cfg_ready_o, always ready): index 0 temp
//    coefficients, 1 and 2 pressure coefficients, 3 P9. Write while idle.
// Timing: one request at a time; in_stall_o is high from acceptance until
//  the result is taken. All products go through one shared shift/add unit
//  taking one multiplier bit per cycle, which also does the restoring divide.
//  Temperature: 3 products. Pressure: 10 products and one divide; a zero
//  divisor ends after 6 products.
// Reset clears coefficients and the fine temperature to zero; no clearing
//  pass. While out_stall_i is high the result holds and no request is taken.
module pressure_temperature_compensation_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ptc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ptc_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);
  import ptc_pkg::*;

  localparam logic [1:0] RegTemp  = 2'd0;
  localparam logic [1:0] RegPLow  = 2'd1;
  localparam logic [1:0] RegPHigh = 2'd2;
  localparam logic [1:0] RegPNine = 2'd3;

  logic [47:0] tc_q;
  logic [63:0] pl_q, ph_q;
  logic [15:0] p9_q;
  logic [31:0] fine_q, fine_d;

  state_e      st_q, st_d;
  logic [3:0]  pc_q, pc_d;
  logic        kind_q, kind_d;
  logic [19:0] adc_q, adc_d;
  logic [63:0] v1_q, v1_d, v2_q, v2_d, sq_q, sq_d, x_q, x_d, p_q, p_d, prod_q, prod_d;
  out_item_t   out_q, out_d;

  unit_req_t   req;
  logic [63:0] op_a, op_b, unit_res;
  logic        unit_done;

  ptc_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (unit_done),
    .result_o(unit_res)
  );

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] asr(logic [63:0] v, int unsigned s);
    return 64'($signed(v) >>> s);
  endfunction

  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {48'd0, tc_q[15:0]};
  assign t2 = sx16(tc_q[31:16]);
  assign t3 = sx16(tc_q[47:32]);
  assign p1 = {48'd0, pl_q[15:0]};
  assign p2 = sx16(pl_q[31:16]);
  assign p3 = sx16(pl_q[47:32]);
  assign p4 = sx16(pl_q[63:48]);
  assign p5 = sx16(ph_q[15:0]);
  assign p6 = sx16(ph_q[31:16]);
  assign p7 = sx16(ph_q[47:32]);
  assign p8 = sx16(ph_q[63:48]);
  assign p9 = sx16(p9_q);

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (st_q != ST_IDLE);
  assign out_valid_o = (st_q == ST_OUT);
  assign out_data_o  = out_q;

  logic [63:0] adc64, fine64, tmp, tval, pval;
  logic [31:0] fine_new;
  assign adc64  = {44'd0, adc_q};
  assign fine64 = {{32{fine_q[31]}}, fine_q};

  always_comb begin
    st_d     = st_q;
    pc_d     = pc_q;
    kind_d   = kind_q;
    adc_d    = adc_q;
    fine_d   = fine_q;
    v1_d     = v1_q;
    v2_d     = v2_q;
    sq_d     = sq_q;
    x_d      = x_q;
    p_d      = p_q;
    prod_d   = prod_q;
    out_d    = out_q;
    req      = '{start: 1'b0, op: OP_MUL};
    op_a     = 64'd0;
    op_b     = 64'd0;
    tmp      = 64'd0;
    tval     = 64'd0;
    pval     = 64'd0;
    fine_new = 32'd0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d = in_data_i.action;
          adc_d  = in_data_i.raw_sample;
          v1_d   = fine64 - 64'd128000;
          pc_d   = 4'd0;
          st_d   = ST_STEP;
        end
      end
      ST_WAIT: begin
        if (unit_done) begin
          prod_d = unit_res;
          pc_d   = pc_q + 4'd1;
          st_d   = ST_STEP;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) st_d = ST_IDLE;
      end
      ST_STEP: begin
        st_d      = ST_WAIT;
        req.start = 1'b1;
        if (!kind_q) begin
          unique case (pc_q)
            4'd0: begin
              op_a = {3'd0, adc64[63:3]} - {t1[62:0], 1'b0};
              op_b = t2;
            end
            4'd1: begin
              x_d  = asr(prod_q, 11);
              op_a = {4'd0, adc64[63:4]} - t1;
              op_b = op_a;
            end
            4'd2: begin
              op_a = asr(prod_q, 12);
              op_b = t3;
            end
            default: begin
              req.start = 1'b0;
              fine_new  = 32'(x_q + asr(prod_q, 14));
              fine_d    = fine_new;
              tmp       = {{32{fine_new[31]}}, fine_new};
              tval      = asr({tmp[61:0], 2'b00} + tmp + 64'd128, 8);
              if ($signed(tval) < -64'sd32768)     tval = 64'hFFFF_FFFF_FFFF_8000;
              else if ($signed(tval) > 64'sd32767) tval = 64'd32767;
              out_d.result_kind       = 1'b0;
              out_d.temperature_centi = tval[15:0];
              out_d.pressure_q24_8    = 25'd0;
              out_d.divide_fault      = 1'b0;
              st_d = ST_OUT;
            end
          endcase
        end else begin
          unique case (pc_q)
            4'd0: begin
              op_a = v1_q;
              op_b = v1_q;
            end
            4'd1: begin
              sq_d = prod_q;
              op_a = prod_q;
              op_b = p6;
            end
            4'd2: begin
              v2_d = prod_q;
              op_a = v1_q;
              op_b = p5;
            end
            4'd3: begin
              v2_d = v2_q + {prod_q[46:0], 17'd0} + {p4[28:0], 35'd0};
              op_a = sq_q;
              op_b = p3;
            end
            4'd4: begin
              x_d  = asr(prod_q, 8);
              op_a = v1_q;
              op_b = p2;
            end
            4'd5: begin
              tmp  = x_q + {prod_q[51:0], 12'd0};
              x_d  = tmp;
              op_a = (64'd1 << 47) + tmp;
              op_b = p1;
            end
            4'd6: begin
              tmp  = asr(prod_q, 33);
              v1_d = tmp;
              if (tmp == 64'd0) begin
                req.start = 1'b0;
                out_d.result_kind       = 1'b1;
                out_d.temperature_centi = 16'sd0;
                out_d.pressure_q24_8    = 25'd0;
                out_d.divide_fault      = 1'b1;
                st_d = ST_OUT;
              end else begin
                op_a = ((64'd1048576 - adc64) << 31) - v2_q;
                op_b = 64'd3125;
              end
            end
            4'd7: begin
              req.op = OP_DIV;
              op_a   = prod_q;
              op_b   = v1_q;
            end
            4'd8: begin
              p_d  = prod_q;
              op_a = asr(prod_q, 13);
              op_b = op_a;
            end
            4'd9: begin
              op_a = prod_q;
              op_b = p9;
            end
            4'd10: begin
              x_d  = asr(prod_q, 25);
              op_a = p8;
              op_b = p_q;
            end
            default: begin
              req.start = 1'b0;
              pval = asr(p_q + x_q + asr(prod_q, 19), 8) + {p7[59:0], 4'd0};
              if (pval[63])                   pval = 64'd0;
              else if (pval > 64'd33554431)   pval = 64'd33554431;
              out_d.result_kind       = 1'b1;
              out_d.temperature_centi = 16'sd0;
              out_d.pressure_q24_8    = pval[24:0];
              out_d.divide_fault      = 1'b0;
              st_d = ST_OUT;
            end
          endcase
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      pc_q   <= 4'd0;
      fine_q <= 32'd0;
      tc_q   <= 48'd0;
      pl_q   <= 64'd0;
      ph_q   <= 64'd0;
      p9_q   <= 16'd0;
    end else begin
      st_q   <= st_d;
      pc_q   <= pc_d;
      fine_q <= fine_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegTemp:  tc_q <= cfg_data_i[47:0];
          RegPLow:  pl_q <= cfg_data_i;
          RegPHigh: ph_q <= cfg_data_i;
          RegPNine: p9_q <= cfg_data_i[15:0];
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    adc_q  <= adc_d;
    v1_q   <= v1_d;
    v2_q   <= v2_d;
    sq_q   <= sq_d;
    x_q    <= x_d;
    p_q    <= p_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

endmodule

>>> bench/tb_pressure_temperature_compensation_core.sv
// Self-checking bench for pressure_temperature_compensation_core.
// Depends on ptc_pkg; predicts each result from its own integer compensation model.
module tb_pressure_temperature_compensation_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ptc_pkg::*;

  localparam logic [1:0] REG_TEMP   = 2'd0;
  localparam logic [1:0] REG_PLOW   = 2'd1;
  localparam logic [1:0] REG_PHIGH  = 2'd2;
  localparam logic [1:0] REG_P9     = 2'd3;
  localparam logic       ACT_TEMP   = 1'b0;
  localparam logic       ACT_PRESS  = 1'b1;
  localparam logic [63:0] PRESS_SAT = 64'd33554431;

  // nominal calibration set
  localparam logic [47:0] CAL_T  = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] CAL_PL = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] CAL_PH = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [15:0] CAL_P9 = 16'd6000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [1:0] cfg_index;
  logic [63:0] cfg_data;

  pressure_temperature_compensation_core u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // predictor state
  logic [47:0] temp_cal;
  logic [63:0] press_cal_lo, press_cal_hi;
  logic [15:0] press_cal_p9;
  logic [31:0] fine_temp;

  in_item_t  pending_requests[$];
  out_item_t expected_results[$];
  int  mismatches = 0;
  bit  quiet = 0;
  bit  in_taken = 0;
  bit  hold_start = 0;
  int  hold_left = 0, stall_burst = 0, send_gap = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] asr(logic [63:0] x, int s);
    return $signed(x) >>> s;
  endfunction

  // truncating signed divide done on magnitudes, so min / -1 wraps
  function automatic logic [63:0] sdiv(logic [63:0] n, logic [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q  = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic out_item_t compensate_reading(in_item_t it);
    out_item_t r;
    logic [63:0] adc, t1, t2, t3, v1, v2, d, f, t, p, q;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    r = '0;
    adc = {44'd0, it.raw_sample};
    if (it.action == ACT_TEMP) begin
      t1 = {48'd0, temp_cal[15:0]};
      t2 = sx16(temp_cal[31:16]);
      t3 = sx16(temp_cal[47:32]);
      v1 = asr(((adc >> 3) - (t1 << 1)) * t2, 11);
      d  = (adc >> 4) - t1;
      v2 = asr(asr(d * d, 12) * t3, 14);
      fine_temp = v1[31:0] + v2[31:0];
      f = {{32{fine_temp[31]}}, fine_temp};
      t = asr(f * 5 + 128, 8);
      if ($signed(t) < -64'sd32768) t = -64'd32768;
      else if ($signed(t) > 64'sd32767) t = 64'd32767;
      r.result_kind = ACT_TEMP;
      r.temperature_centi = t[15:0];
    end else begin
      p1 = {48'd0, press_cal_lo[15:0]};
      p2 = sx16(press_cal_lo[31:16]);
      p3 = sx16(press_cal_lo[47:32]);
      p4 = sx16(press_cal_lo[63:48]);
      p5 = sx16(press_cal_hi[15:0]);
      p6 = sx16(press_cal_hi[31:16]);
      p7 = sx16(press_cal_hi[47:32]);
      p8 = sx16(press_cal_hi[63:48]);
      p9 = sx16(press_cal_p9);
      v1 = {{32{fine_temp[31]}}, fine_temp} - 64'd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
      v1 = asr(((64'd1 << 47) + v1) * p1, 33);
      r.result_kind = ACT_PRESS;
      if (v1 == 0) begin
        r.divide_fault = 1'b1;
      end else begin
        p = 64'd1048576 - adc;
        p = sdiv(((p << 31) - v2) * 64'd3125, v1);
        q = asr(p, 13);
        v1 = asr(p9 * q * q, 25);
        v2 = asr(p8 * p, 19);
        p = asr(p + v1 + v2, 8) + (p7 << 4);
        if (p[63]) p = 0;
        else if (p > PRESS_SAT) p = PRESS_SAT;
        r.pressure_q24_8 = p[24:0];
      end
    end
    return r;
  endfunction

  // request driver
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        in_data  <= pending_requests.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure; long hold counted here
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      hold_left   <= 0;
      stall_burst <= 0;
    end else if (hold_start) begin
      hold_start = 0;
      hold_left <= 600;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_burst > 0) begin
      stall_burst <= stall_burst - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_burst <= $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // predict on acceptance, check on result
  always @(posedge clk) begin
    out_item_t exp_r;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) expected_results.push_back(compensate_reading(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.result_kind != out_data.result_kind
            || exp_r.temperature_centi != out_data.temperature_centi
            || exp_r.pressure_q24_8 != out_data.pressure_q24_8
            || exp_r.divide_fault != out_data.divide_fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: kind %0d/%0d temp %0d/%0d press %0d/%0d fault %0d/%0d",
                     exp_r.result_kind, out_data.result_kind,
                     exp_r.temperature_centi, out_data.temperature_centi,
                     exp_r.pressure_q24_8, out_data.pressure_q24_8,
                     exp_r.divide_fault, out_data.divide_fault);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TEMP:  temp_cal     = val[47:0];
      REG_PLOW:  press_cal_lo = val;
      REG_PHIGH: press_cal_hi = val;
      default:   press_cal_p9 = val[15:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (pending_requests.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_cal(logic [47:0] t, logic [63:0] pl, logic [63:0] ph, logic [15:0] p9);
    wait_drained();
    write_reg(REG_TEMP, {16'd0, t});
    write_reg(REG_PLOW, pl);
    write_reg(REG_PHIGH, ph);
    write_reg(REG_P9, {48'd0, p9});
  endtask

  function automatic in_item_t reading(logic act, logic [19:0] raw);
    in_item_t it;
    it.action = act;
    it.raw_sample = raw;
    return it;
  endfunction

  // mostly a temperature reading followed by pressure readings, some noise
  task automatic queue_readings(int n);
    int k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 6) != 0) begin
        pending_requests.push_back(reading(ACT_TEMP, 20'($urandom_range(400000, 600000))));
        k++;
        repeat ($urandom_range(1, 3)) begin
          pending_requests.push_back(reading(ACT_PRESS, 20'($urandom_range(250000, 550000))));
          k++;
        end
      end else begin
        pending_requests.push_back(reading(1'($urandom_range(0, 1)),
                                           20'($urandom_range(0, 1048575))));
        k++;
      end
    end
  endtask

  function automatic logic [15:0] jitter(logic [15:0] v);
    return v ^ 16'($urandom_range(0, 63));
  endfunction

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    temp_cal = '0;
    press_cal_lo = '0;
    press_cal_hi = '0;
    press_cal_p9 = '0;
    fine_temp = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero coefficients: pressure before any temperature hits the zero divisor
    pending_requests.push_back(reading(ACT_PRESS, 20'd415148));
    pending_requests.push_back(reading(ACT_TEMP, 20'd519888));
    pending_requests.push_back(reading(ACT_PRESS, 20'hFFFFF));

    load_cal(CAL_T, CAL_PL, CAL_PH, CAL_P9);
    pending_requests.push_back(reading(ACT_PRESS, 20'd415148));
    pending_requests.push_back(reading(ACT_TEMP, 20'd519888));
    pending_requests.push_back(reading(ACT_PRESS, 20'd415148));
    pending_requests.push_back(reading(ACT_PRESS, 20'd0));
    pending_requests.push_back(reading(ACT_PRESS, 20'hFFFFF));
    pending_requests.push_back(reading(ACT_TEMP, 20'd0));
    pending_requests.push_back(reading(ACT_PRESS, 20'd300000));
    pending_requests.push_back(reading(ACT_TEMP, 20'hFFFFF));
    pending_requests.push_back(reading(ACT_PRESS, 20'd300000));

    // extremes: all ones, most-negative, then most-positive fields (saturation and wrap)
    load_cal('1, '1, '1, '1);
    pending_requests.push_back(reading(ACT_TEMP, 20'hFFFFF));
    pending_requests.push_back(reading(ACT_PRESS, 20'd0));
    pending_requests.push_back(reading(ACT_TEMP, 20'd0));
    pending_requests.push_back(reading(ACT_PRESS, 20'hFFFFF));
    load_cal({3{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 16'h8000);
    pending_requests.push_back(reading(ACT_TEMP, 20'hFFFFF));
    pending_requests.push_back(reading(ACT_PRESS, 20'h55555));
    pending_requests.push_back(reading(ACT_TEMP, 20'd0));
    pending_requests.push_back(reading(ACT_PRESS, 20'hAAAAA));
    load_cal({3{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF);
    pending_requests.push_back(reading(ACT_TEMP, 20'd123456));
    pending_requests.push_back(reading(ACT_PRESS, 20'd654321));

    // nominal set with a long output hold: input side backs up
    load_cal(CAL_T, CAL_PL, CAL_PH, CAL_P9);
    hold_start = 1;
    queue_readings(90);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2)
        load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                 16'($urandom));
      else
        load_cal({jitter(CAL_T[47:32]), jitter(CAL_T[31:16]), jitter(CAL_T[15:0])},
                 {jitter(CAL_PL[63:48]), jitter(CAL_PL[47:32]), jitter(CAL_PL[31:16]),
                  jitter(CAL_PL[15:0])},
                 {jitter(CAL_PH[63:48]), jitter(CAL_PH[47:32]), jitter(CAL_PH[31:16]),
                  jitter(CAL_PH[15:0])},
                 jitter(CAL_P9));
      queue_readings(80);
    end

    // closing stretch without idling
    wait_drained();
    quiet = 1;
    queue_readings(60);
    wait_drained();
    repeat (800) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
